@@ design/irsp_pkg.sv @@
// Shared types, codes and helpers for the identifier regex syntax parser.
// No dependencies; used by every other file of the block.
package irsp_pkg;

  localparam int unsigned IndexBits = 16;
  localparam int unsigned ArgBits   = 16;
  localparam int unsigned CharBits  = 21;
  localparam int unsigned ClassBits = 4;
  localparam int unsigned StartBits = 16;
  localparam int unsigned MaxRes    = 4;
  localparam int unsigned ResIdxBits = $clog2(MaxRes);
  localparam int unsigned ResCntBits = $clog2(MaxRes + 1);

  localparam logic [IndexBits-1:0] IndexMax = '1;

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_FIRST,
    PH_CONCAT,
    PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    LX_END      = 4'd0,
    LX_CHAR     = 4'd1,
    LX_CLASS    = 4'd2,
    LX_NQ_CLASS = 4'd3,
    LX_OR       = 4'd4,
    LX_OPEN     = 4'd5,
    LX_CLOSE    = 4'd6,
    LX_OTHER    = 4'd7,
    LX_START    = 4'd8
  } lexeme_e;

  typedef enum logic [2:0] {
    RK_CHAR  = 3'd0,
    RK_CLASS = 3'd1,
    RK_MCAT  = 3'd2,
    RK_OR    = 3'd3,
    RK_ERR   = 3'd4,
    RK_DONE  = 3'd5
  } rkind_e;

  typedef enum logic [2:0] {
    ER_MISSING_OPEN  = 3'd0,
    ER_EXPECT_CHAR   = 3'd1,
    ER_EXPECT_CHAR_CLOSE = 3'd2,
    ER_NON_QUOTE     = 3'd3,
    ER_EARLY_END     = 3'd4,
    ER_OVERFLOW      = 3'd5
  } err_e;

  typedef struct packed {
    logic [3:0]           kind;
    logic [CharBits-1:0]  ch;
    logic [ClassBits-1:0] cls;
    logic [StartBits-1:0] start;
  } item_t;

  typedef struct packed {
    rkind_e               kind;
    logic [CharBits-1:0]  ch;
    logic [ClassBits-1:0] cls;
    logic [IndexBits-1:0] a1;
    logic [IndexBits-1:0] a2;
    err_e                 err;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0]     res;
    logic [ResCntBits-1:0] n;
  } batch_t;

  function automatic res_t mk_res(rkind_e kind, logic [CharBits-1:0] ch,
                                  logic [ClassBits-1:0] cls,
                                  logic [IndexBits-1:0] a1,
                                  logic [IndexBits-1:0] a2, err_e err);
    res_t r;
    r.kind = kind;
    r.ch   = ch;
    r.cls  = cls;
    r.a1   = a1;
    r.a2   = a2;
    r.err  = err;
    return r;
  endfunction

  function automatic res_t mk_err(err_e err);
    return mk_res(RK_ERR, '0, '0, '0, '0, err);
  endfunction

endpackage

@@ design/irsp_core.sv @@
// Parser state and the single-pass step logic: one item in, up to four results out.
// Depends on irsp_pkg.
module irsp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  irsp_pkg::item_t item_i,
  output irsp_pkg::batch_t batch_o
);
  import irsp_pkg::*;

  phase_e               ph_q, ph_d;
  logic [IndexBits-1:0] ni_q, ni_d;
  logic [IndexBits-1:0] cf_q, cf_d;
  logic [1:0]           len_q, len_d;   // saturates at two, only "more than one" matters
  logic [1:0]           ac_q, ac_d;
  logic [IndexBits-1:0] al_q, al_d;

  batch_t               b;
  logic [IndexBits-1:0] ni;

  logic is_elem, is_or, is_open, is_close, is_end, is_start;
  logic do_elem, elem_first, do_flush;

  always_comb begin
    is_elem  = 1'b0;
    is_or    = 1'b0;
    is_open  = 1'b0;
    is_close = 1'b0;
    is_end   = 1'b0;
    is_start = 1'b0;
    case (item_i.kind)
      LX_END:                         is_end   = 1'b1;
      LX_CHAR, LX_CLASS, LX_NQ_CLASS: is_elem  = 1'b1;
      LX_OR:                          is_or    = 1'b1;
      LX_OPEN:                        is_open  = 1'b1;
      LX_CLOSE:                       is_close = 1'b1;
      LX_START:                       is_start = 1'b1;
      default:                        ;
    endcase
  end

  always_comb begin
    b          = '0;
    ni         = ni_q;
    ph_d       = ph_q;
    cf_d       = cf_q;
    len_d      = len_q;
    ac_d       = ac_q;
    al_d       = al_q;
    do_elem    = 1'b0;
    elem_first = 1'b0;
    do_flush   = 1'b0;

    if (is_start) begin
      ph_d  = PH_OPEN;
      ni    = IndexBits'(item_i.start);
      cf_d  = '0;
      len_d = '0;
      ac_d  = '0;
      al_d  = '0;
    end else if (ph_q != PH_DONE) begin
      if (is_end) begin
        b.res[b.n[ResIdxBits-1:0]] = mk_err(ER_EARLY_END);
        b.n = b.n + 1'b1;
        do_flush = (ph_q == PH_FIRST) || (ph_q == PH_CONCAT);
        ph_d = PH_DONE;
      end else begin
        case (ph_q)
          PH_OPEN: begin
            ph_d = PH_FIRST;
            if (!is_open) begin
              b.res[b.n[ResIdxBits-1:0]] = mk_err(ER_MISSING_OPEN);
              b.n = b.n + 1'b1;
              if (is_elem) begin
                do_elem    = 1'b1;
                elem_first = 1'b1;
                ph_d       = PH_CONCAT;
              end else if (is_close) begin
                ph_d = PH_DONE;
              end
            end
          end
          PH_FIRST: begin
            if (is_elem) begin
              do_elem    = 1'b1;
              elem_first = 1'b1;
              ph_d       = PH_CONCAT;
            end else begin
              b.res[b.n[ResIdxBits-1:0]] = mk_err(ER_EXPECT_CHAR);
              b.n = b.n + 1'b1;
              if (is_close) ph_d = PH_DONE;
            end
          end
          default: begin
            if (is_elem) begin
              do_elem = 1'b1;
            end else if (is_or) begin
              do_flush = 1'b1;
              ph_d     = PH_FIRST;
            end else if (is_close) begin
              do_flush = 1'b1;
              ph_d     = PH_DONE;
            end else begin
              b.res[b.n[ResIdxBits-1:0]] = mk_err(ER_EXPECT_CHAR_CLOSE);
              b.n = b.n + 1'b1;
            end
          end
        endcase
      end

      // element definition, with the non-quote warning ahead of it
      if (do_elem) begin
        if (item_i.kind == LX_NQ_CLASS) begin
          b.res[b.n[ResIdxBits-1:0]] = mk_err(ER_NON_QUOTE);
          b.n = b.n + 1'b1;
        end
        if (ni == IndexMax) begin
          b.res[b.n[ResIdxBits-1:0]] = mk_err(ER_OVERFLOW);
        end else if (item_i.kind == LX_CHAR) begin
          b.res[b.n[ResIdxBits-1:0]] = mk_res(RK_CHAR, item_i.ch, '0, '0, '0,
                                              ER_MISSING_OPEN);
          ni = ni + 1'b1;
        end else begin
          b.res[b.n[ResIdxBits-1:0]] = mk_res(RK_CLASS, '0, item_i.cls, '0, '0,
                                              ER_MISSING_OPEN);
          ni = ni + 1'b1;
        end
        b.n = b.n + 1'b1;
        if (elem_first) begin
          cf_d  = ni - 1'b1;
          len_d = 2'd1;
        end else if (len_q != 2'd2) begin
          len_d = len_q + 1'b1;
        end
      end

      // close the alternative: multiconcat if needed, then or with any left operand
      if (do_flush) begin
        if (len_q == 2'd2) begin
          if (ni == IndexMax) begin
            b.res[b.n[ResIdxBits-1:0]] = mk_err(ER_OVERFLOW);
          end else begin
            b.res[b.n[ResIdxBits-1:0]] = mk_res(RK_MCAT, '0, '0, cf_q, ni - 1'b1,
                                                ER_MISSING_OPEN);
            ni = ni + 1'b1;
          end
          b.n = b.n + 1'b1;
        end
        if (ac_q != 2'd2) ac_d = ac_q + 1'b1;
        if (ac_d != 2'd1) begin
          if (ni == IndexMax) begin
            b.res[b.n[ResIdxBits-1:0]] = mk_err(ER_OVERFLOW);
          end else begin
            b.res[b.n[ResIdxBits-1:0]] = mk_res(RK_OR, '0, '0, al_q, ni - 1'b1,
                                                ER_MISSING_OPEN);
            ni = ni + 1'b1;
          end
          b.n = b.n + 1'b1;
        end
        al_d = ni - 1'b1;
        if (is_or) len_d = '0;
      end

      if (ph_d == PH_DONE) begin
        b.res[b.n[ResIdxBits-1:0]] = mk_res(RK_DONE, '0, '0, '0, '0, ER_MISSING_OPEN);
        b.n = b.n + 1'b1;
      end
    end
    ni_d = ni;
  end

  assign batch_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_OPEN;
      ni_q  <= '0;
      cf_q  <= '0;
      len_q <= '0;
      ac_q  <= '0;
      al_q  <= '0;
    end else if (fire_i) begin
      ph_q  <= ph_d;
      ni_q  <= ni_d;
      cf_q  <= cf_d;
      len_q <= len_d;
      ac_q  <= ac_d;
      al_q  <= al_d;
    end
  end

endmodule

@@ design/irsp_out_buf.sv @@
// Result register: holds one item's results and hands them out one beat per cycle while out_ready_i is high.
// Depends on irsp_pkg.
module irsp_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  irsp_pkg::batch_t batch_i,
  output logic             can_load_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output irsp_pkg::res_t   res_o,
  output logic             last_o
);
  import irsp_pkg::*;

  res_t [MaxRes-1:0]     res_q;
  logic [ResCntBits-1:0] cnt_q;
  logic [ResIdxBits-1:0] idx_q;

  assign out_valid_o = (cnt_q != '0);
  assign last_o      = (cnt_q == ResCntBits'(1));
  assign res_o       = res_q[idx_q];
  // free now, or the final beat leaves this cycle
  assign can_load_o  = !out_valid_o || (last_o && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.n;
      idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      cnt_q <= cnt_q - 1'b1;
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= batch_i.res;
  end

endmodule

@@ design/identifier_regex_syntax_parser_unit.sv @@
// Top level of the identifier regex syntax parser: input register, step core, result buffer.
// Depends on irsp_pkg, irsp_core and irsp_out_buf.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, lexeme fields      | consumer
//   out     | out_valid_o/out_ready_i, result fields    | producer
//
// An item causes n results (0 to 4); the result buffer hands out one beat per
// cycle while out_ready_i is high. First result is valid once the item has passed
// the input register and been loaded into the buffer. The input register takes a
// new item while results still wait, so a stalled output holds at most one further item.
// Reset is asynchronous, active low, and puts the parser in the expect-open phase.
module identifier_regex_syntax_parser_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [3:0]                           lexeme_kind_i,
  input  logic [irsp_pkg::CharBits-1:0]        char_value_i,
  input  logic [irsp_pkg::ClassBits-1:0]       class_index_i,
  input  logic [irsp_pkg::StartBits-1:0]       start_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [2:0]                           result_kind_o,
  output logic [irsp_pkg::CharBits-1:0]        out_char_o,
  output logic [irsp_pkg::ClassBits-1:0]       out_class_o,
  output logic [irsp_pkg::ArgBits-1:0]         arg_first_o,
  output logic [irsp_pkg::ArgBits-1:0]         arg_second_o,
  output logic [2:0]                           error_code_o,
  output logic                                 last_o
);
  import irsp_pkg::*;

  item_t  item_q;
  logic   item_vld_q;
  logic   can_load;
  logic   fire;
  batch_t batch;
  res_t   res;

  assign fire       = item_vld_q && can_load;
  assign in_ready_o = !item_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.kind  <= lexeme_kind_i;
      item_q.ch    <= char_value_i;
      item_q.cls   <= class_index_i;
      item_q.start <= start_index_i;
    end
  end

  irsp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item_q),
    .batch_o (batch)
  );

  irsp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .batch_i     (batch),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign result_kind_o = res.kind;
  assign out_char_o    = res.ch;
  assign out_class_o   = res.cls;
  assign arg_first_o   = ArgBits'(res.a1);
  assign arg_second_o  = ArgBits'(res.a2);
  assign error_code_o  = res.err;

endmodule
